// File: sv/edl_pkg.sv
// Types and constants shared by the echo distance to LCD byte block.
`timescale 1ns / 1ps
`default_nettype none
package edl_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgMaxDist   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBacklight = CfgIdxW'(1);

  localparam logic [13:0] MaxDistReset   = 14'd4000;
  localparam logic        BacklightReset = 1'b1;
  localparam logic [13:0] DisplayCap     = 14'd9999;

  // Distance arithmetic: mm = (width*343 + 1000) / 2000
  localparam logic [8:0]  SoundMul   = 9'd343;
  localparam logic [24:0] RoundAdd   = 25'd1000;
  // floor(n/125) = (n * Recip125) >> 28 for n < 2^21
  localparam logic [21:0] Recip125   = 22'd2147484;
  // floor(x/10) = (x * Recip10Wide) >> 19 for x < 16384
  localparam logic [16:0] Recip10Wide = 17'd52429;
  // floor(x/10) = (x * Recip10Narrow) >> 11 for x < 1029
  localparam logic [7:0]  Recip10Narrow = 8'd205;

  // LCD expander byte flags and characters
  localparam logic [7:0] ClearCmd = 8'h01;
  localparam logic [7:0] FlagRs   = 8'h01;
  localparam logic [7:0] FlagEn   = 8'h04;
  localparam logic [7:0] FlagBl   = 8'h08;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChC      = 8'h63;
  localparam logic [7:0] ChM      = 8'h6D;

  // Classified measurement handed from front to back
  typedef struct packed {
    logic [13:0] mm;
    logic [1:0]  nd;    // number of centimetre digits, 1 to 3
    logic [3:0]  d2;
    logic [3:0]  d1;
    logic [3:0]  d0;
    logic [3:0]  frac;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/edl_if.sv
// Channel interfaces: measurement input, expander byte output, configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface edl_meas_if;
  logic        valid;
  logic        ready;
  logic [15:0] rise_time;
  logic [15:0] fall_time;
  modport source (output valid, rise_time, fall_time, input ready);
  modport sink   (input valid, rise_time, fall_time, output ready);
endinterface

interface edl_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  expander_byte;
  logic        end_of_transfer;
  logic [13:0] distance_mm;
  logic        last;
  modport source (output valid, expander_byte, end_of_transfer, distance_mm, last,
                  input ready);
  modport sink   (input valid, expander_byte, end_of_transfer, distance_mm, last,
                  output ready);
endinterface

interface edl_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// File: sv/edl_front.sv
// Front pipeline: pulse width to millimetres, clamp, split into decimal digits.
`timescale 1ns / 1ps
`default_nettype none
module edl_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [15:0]      rise_time_i,
  input  wire logic [15:0]      fall_time_i,
  input  wire logic [13:0]      max_dist_i,
  output logic                  ent_valid_o,
  input  wire logic             ent_ready_i,
  output edl_pkg::entry_t       ent_o
);
  import edl_pkg::*;

  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic        adv;
  logic [24:0] prod_q;
  logic [13:0] mm2_q;
  logic [13:0] mm3_q;
  logic [9:0]  whole3_q;
  logic [3:0]  frac3_q;
  logic [13:0] mm4_q;
  logic [6:0]  tens4_q;
  logic [3:0]  d04_q;
  logic [3:0]  frac4_q;
  logic [1:0]  nd4_q;
  entry_t      ent_q;

  logic [15:0] width;
  logic [24:0] rounded;
  logic [42:0] q125;
  logic [13:0] lim;
  logic [13:0] mm_clamp;
  logic [30:0] q10w;
  logic [9:0]  whole;
  logic [17:0] q10a;
  logic [6:0]  tens;
  logic [14:0] q10b;
  logic [3:0]  hund;

  // Stall the whole pipe only when the last stage cannot hand off
  assign adv        = !(v5_q && !ent_ready_i);
  assign in_ready_o = adv;

  assign width    = fall_time_i - rise_time_i;
  assign rounded  = prod_q + RoundAdd;
  assign q125     = 43'(rounded[24:4]) * 43'(Recip125);
  assign lim      = (max_dist_i < DisplayCap) ? max_dist_i : DisplayCap;
  assign mm_clamp = (mm2_q > lim) ? lim : mm2_q;
  assign q10w     = 31'(mm_clamp) * 31'(Recip10Wide);
  assign whole    = q10w[28:19];
  assign q10a     = 18'(whole3_q) * 18'(Recip10Narrow);
  assign tens     = q10a[17:11];
  assign q10b     = 15'(tens4_q) * 15'(Recip10Narrow);
  assign hund     = q10b[14:11];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= 25'(width) * 25'(SoundMul);
      mm2_q    <= q125[41:28];
      mm3_q    <= mm_clamp;
      whole3_q <= whole;
      frac3_q  <= 4'(mm_clamp - 14'(whole) * 14'd10);
      mm4_q    <= mm3_q;
      tens4_q  <= tens;
      d04_q    <= 4'(whole3_q - 10'(tens) * 10'd10);
      frac4_q  <= frac3_q;
      if (whole3_q >= 10'd100) begin
        nd4_q <= 2'd3;
      end else if (whole3_q >= 10'd10) begin
        nd4_q <= 2'd2;
      end else begin
        nd4_q <= 2'd1;
      end
      ent_q.mm   <= mm4_q;
      ent_q.nd   <= nd4_q;
      ent_q.d2   <= hund;
      ent_q.d1   <= 4'(tens4_q - 7'(hund) * 7'd10);
      ent_q.d0   <= d04_q;
      ent_q.frac <= frac4_q;
    end
  end

  assign ent_valid_o = v5_q;
  assign ent_o       = ent_q;

endmodule
`default_nettype wire

// File: sv/edl_fifo.sv
// Short register queue between the front pipeline and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
module edl_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  input  wire edl_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i,
  output edl_pkg::entry_t  pop_data_o
);
  import edl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/edl_back.sv
// Byte sequencer: walks the characters of one reading and emits four expander bytes each.
`timescale 1ns / 1ps
`default_nettype none
module edl_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             ent_valid_i,
  output logic                  ent_ready_o,
  input  wire edl_pkg::entry_t  ent_i,
  input  wire logic             backlight_i,
  edl_byte_if.source            bytes_o
);
  import edl_pkg::*;

  logic        busy_q;
  entry_t      ent_q;
  logic [3:0]  ci_q;
  logic [1:0]  ph_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_eot_q;
  logic [13:0] out_mm_q;
  logic        out_last_q;

  logic        emit, final_char, fin, take;
  logic [3:0]  tail;
  logic [1:0]  dsel;
  logic [3:0]  digit;
  logic [7:0]  ch, rs, bl, hi, lo, byte_d;

  assign emit       = busy_q && (!out_valid_q || bytes_o.ready);
  assign tail       = ci_q - 4'(ent_q.nd) - 4'd1;
  assign final_char = (tail == 4'd4);
  assign fin        = emit && (ph_q == 2'd3) && final_char;
  assign ent_ready_o = !busy_q || fin;
  assign take       = ent_valid_i && ent_ready_o;

  // Digits go out most significant first
  assign dsel = ent_q.nd - ci_q[1:0];
  always_comb begin
    case (dsel)
      2'd2:    digit = ent_q.d2;
      2'd1:    digit = ent_q.d1;
      default: digit = ent_q.d0;
    endcase
  end

  always_comb begin
    rs = FlagRs;
    if (ci_q == 4'd0) begin
      ch = ClearCmd;
      rs = 8'h00;
    end else if (ci_q <= 4'(ent_q.nd)) begin
      ch = ChZero + 8'(digit);
    end else begin
      case (tail)
        4'd0:    ch = ChDot;
        4'd1:    ch = ChZero + 8'(ent_q.frac);
        4'd2:    ch = ChSpace;
        4'd3:    ch = ChC;
        default: ch = ChM;
      endcase
    end
  end

  assign bl = backlight_i ? FlagBl : 8'h00;
  assign hi = (ch & 8'hF0) | rs | bl;
  assign lo = ({ch[3:0], 4'h0}) | rs | bl;

  always_comb begin
    case (ph_q)
      2'd0:    byte_d = hi | FlagEn;
      2'd1:    byte_d = hi;
      2'd2:    byte_d = lo | FlagEn;
      default: byte_d = lo;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ci_q        <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        ci_q   <= '0;
        ph_q   <= '0;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          ci_q <= ci_q + 4'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (bytes_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ent_q <= ent_i;
    end
    if (emit) begin
      out_byte_q <= byte_d;
      out_eot_q  <= (ph_q == 2'd3);
      out_mm_q   <= ent_q.mm;
      out_last_q <= fin;
    end
  end

  assign bytes_o.valid           = out_valid_q;
  assign bytes_o.expander_byte   = out_byte_q;
  assign bytes_o.end_of_transfer = out_eot_q;
  assign bytes_o.distance_mm     = out_mm_q;
  assign bytes_o.last            = out_last_q;

endmodule
`default_nettype wire

// File: sv/echo_distance_to_lcd_bytes_core.sv
// Top level: echo capture pair in, LCD expander bytes out.
//
// meas_i takes one request per echo: rise_time and fall_time captures. The
// distance in millimetres is computed, clamped to max_distance_mm (and to
// 9999), and printed as "<cm>.<tenths> cm" after a clear command.
// bytes_o delivers one expander byte per accepted transfer, four per
// character, with end_of_transfer on every fourth byte and last on the final
// byte of the reading. distance_mm repeats on every byte of a reading.
// cfg_i writes register 0 (max_distance_mm) or 1 (backlight_on); other
// indexes are dropped. It is always ready and should be used while idle.
// The first byte of a reading passes the 5 front stages, the first loaded at
// the accepting edge, then queue, sequencer load and output register.
// Throughput: one byte per cycle while the receiver is ready; a reading
// yields 28 to 36 bytes, so the byte sequencer sets the request rate. The front
// pipeline and the queue take new requests while the sequencer works.
// When the receiver stalls, the output register holds its byte, the queue
// fills and then meas_i.ready drops. Reset empties the pipe and queue and
// loads max_distance_mm = 4000 and backlight_on = 1.
`timescale 1ns / 1ps
`default_nettype none
module echo_distance_to_lcd_bytes_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  edl_meas_if.sink    meas_i,
  edl_byte_if.source  bytes_o,
  edl_cfg_if.sink     cfg_i
);
  import edl_pkg::*;

  logic [13:0] max_dist_q;
  logic        backlight_q;

  logic        f_valid, f_ready, b_valid, b_ready;
  entry_t      f_data, b_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= MaxDistReset;
      backlight_q <= BacklightReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMaxDist:   max_dist_q  <= cfg_i.wdata[13:0];
        CfgBacklight: backlight_q <= cfg_i.wdata[0];
        default:      ;
      endcase
    end
  end

  edl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (meas_i.valid),
    .in_ready_o  (meas_i.ready),
    .rise_time_i (meas_i.rise_time),
    .fall_time_i (meas_i.fall_time),
    .max_dist_i  (max_dist_q),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready),
    .ent_o       (f_data)
  );

  edl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  edl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (b_valid),
    .ent_ready_o (b_ready),
    .ent_i       (b_data),
    .backlight_i (backlight_q),
    .bytes_o     (bytes_o)
  );

endmodule
`default_nettype wire

// File: sv/edl_checker.sv
// Port-level checks on the expander byte stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module edl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] exp_byte,
  input wire logic       eot,
  input wire logic       last
);

  // A byte waiting on the receiver stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> valid)
    else $error("output request dropped while stalled");

  // A reading always ends on the final byte of a send
  a_last_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && last |-> eot)
    else $error("last byte not at end of a send");

  // The closing byte of a send never carries the enable strobe
  a_eot_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && eot |-> !exp_byte[2])
    else $error("enable set on final byte of a send");

  // Read/write bit of the expander stays low
  a_rw_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid |-> !exp_byte[1])
    else $error("read/write bit set in expander byte");

endmodule

bind echo_distance_to_lcd_bytes_core edl_checker u_edl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid    (bytes_o.valid),
  .ready    (bytes_o.ready),
  .exp_byte (bytes_o.expander_byte),
  .eot      (bytes_o.end_of_transfer),
  .last     (bytes_o.last)
);
`default_nettype wire

// File: sim/tb_echo_distance_to_lcd_bytes_core.sv
// Testbench for echo_distance_to_lcd_bytes_core: predicts LCD expander bytes per echo and checks them.
`timescale 1ns / 1ps
module tb_echo_distance_to_lcd_bytes_core;
  import edl_pkg::*;

  localparam int unsigned TimeoutNs    = 40_000_000;
  localparam int unsigned DrainLimit   = 80_000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxPrinted   = 40;
  localparam logic [3:0]  CfgUnused    = 4'd7;

  typedef struct packed {
    logic [7:0]  xbyte;
    logic        eot;
    logic [13:0] dist_mm;
    logic        fin;
  } lcd_byte_t;

  logic clk;
  logic rst_n;

  edl_meas_if meas();
  edl_byte_if bytes();
  edl_cfg_if  cfg();

  echo_distance_to_lcd_bytes_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .meas_i  (meas),
    .bytes_o (bytes),
    .cfg_i   (cfg)
  );

  // Shadow registers and pending bytes
  logic [13:0]  max_mm_q;
  logic         backlight_q;
  lcd_byte_t    lcd_bytes_due[$];
  int unsigned  mismatches;

  bit           tx_calm;
  bit           rx_calm;
  int unsigned  rx_hold_cycles;
  int unsigned  rx_stall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // Four expander bytes per character: high nibble strobed, then low nibble strobed
  function automatic void queue_lcd_send(input logic [7:0] ch, input logic [7:0] rs,
                                         input logic [13:0] dist_mm);
    logic [7:0] bl;
    logic [7:0] hi;
    logic [7:0] lo;
    bl = backlight_q ? FlagBl : 8'h00;
    hi = (ch & 8'hF0) | rs | bl;
    lo = {ch[3:0], 4'h0} | rs | bl;
    lcd_bytes_due.push_back('{hi | FlagEn, 1'b0, dist_mm, 1'b0});
    lcd_bytes_due.push_back('{hi,          1'b0, dist_mm, 1'b0});
    lcd_bytes_due.push_back('{lo | FlagEn, 1'b0, dist_mm, 1'b0});
    lcd_bytes_due.push_back('{lo,          1'b1, dist_mm, 1'b0});
  endfunction

  function automatic void predict_lcd_bytes(input logic [15:0] rise, input logic [15:0] fall);
    logic [15:0] width;
    int unsigned mm;
    int unsigned cap;
    int unsigned whole;
    logic [13:0] dist_mm;
    width = fall - rise;
    mm = (32'(width) * 343 + 1000) / 2000;
    cap = (max_mm_q < DisplayCap) ? 32'(max_mm_q) : 32'(DisplayCap);
    if (mm > cap) mm = cap;
    dist_mm = 14'(mm);
    whole = mm / 10;
    queue_lcd_send(ClearCmd, 8'h00, dist_mm);
    // print centimetres without leading zeros
    if (whole >= 100) queue_lcd_send(ChZero + 8'(whole / 100), FlagRs, dist_mm);
    if (whole >= 10) queue_lcd_send(ChZero + 8'((whole / 10) % 10), FlagRs, dist_mm);
    queue_lcd_send(ChZero + 8'(whole % 10), FlagRs, dist_mm);
    queue_lcd_send(ChDot, FlagRs, dist_mm);
    queue_lcd_send(ChZero + 8'(mm % 10), FlagRs, dist_mm);
    queue_lcd_send(ChSpace, FlagRs, dist_mm);
    queue_lcd_send(ChC, FlagRs, dist_mm);
    queue_lcd_send(ChM, FlagRs, dist_mm);
    lcd_bytes_due[lcd_bytes_due.size() - 1].fin = 1'b1;
  endfunction

  // Leaves valid high after the request is taken; a gap in the next call or a drain drops it
  task automatic send_reading(input logic [15:0] rise, input logic [15:0] fall);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      meas.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas.valid     <= 1'b1;
    meas.rise_time <= rise;
    meas.fall_time <= fall;
    do @(posedge clk); while (!meas.ready);
    predict_lcd_bytes(rise, fall);
  endtask

  task automatic send_random_reading();
    logic [15:0] rise;
    logic [15:0] width;
    rise = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    width = 16'($urandom_range(0, 60));
      2, 3:    width = 16'($urandom_range(61, 600));
      4, 5, 6: width = 16'($urandom_range(601, 24000));
      7:       width = 16'((int'(max_mm_q) * 2000) / 343 + $urandom_range(0, 12));
      default: width = 16'($urandom);
    endcase
    send_reading(rise, rise + width);
  endtask

  task automatic drain_readings();
    int unsigned waited;
    meas.valid <= 1'b0;
    waited = 0;
    while (lcd_bytes_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (lcd_bytes_due.size() != 0) begin
      note_mismatch("bytes never delivered", lcd_bytes_due.size(), 0);
      lcd_bytes_due.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Keeps cfg.valid high so that back-to-back writes need no gap; release_cfg drops it
  task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CfgMaxDist) max_mm_q = data[13:0];
    else if (idx == CfgBacklight) backlight_q = data[0];
  endtask

  task automatic release_cfg();
    cfg.valid <= 1'b0;
  endtask

  // Receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      bytes.ready <= 1'b0;
    end else if (rx_hold_cycles != 0) begin
      bytes.ready    <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else if (rx_stall != 0) begin
      bytes.ready <= 1'b0;
      rx_stall    <= rx_stall - 1;
    end else begin
      bytes.ready <= 1'b1;
      if (!rx_calm) rx_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_bytes
    lcd_byte_t want;
    if (rst_n && bytes.valid && bytes.ready) begin
      if (lcd_bytes_due.size() == 0) begin
        note_mismatch("byte with nothing pending", bytes.expander_byte, 0);
      end else begin
        want = lcd_bytes_due.pop_front();
        if (bytes.expander_byte !== want.xbyte)
          note_mismatch("expander_byte", bytes.expander_byte, want.xbyte);
        if (bytes.end_of_transfer !== want.eot)
          note_mismatch("end_of_transfer", bytes.end_of_transfer, want.eot);
        if (bytes.distance_mm !== want.dist_mm)
          note_mismatch("distance_mm", bytes.distance_mm, want.dist_mm);
        if (bytes.last !== want.fin)
          note_mismatch("last", bytes.last, want.fin);
      end
    end
  end

  task automatic test_reset_defaults();
    send_reading(16'h0000, 16'h0000);
    send_reading(16'h1234, 16'h1234);
    send_reading(16'h0000, 16'h0002);
    send_reading(16'h0000, 16'h0003);
    send_reading(16'h0000, 16'h0006);
    // fall capture earlier than rise: width wraps
    send_reading(16'hFFF0, 16'h0010);
    send_reading(16'hFFFF, 16'hFFFE);
    send_reading(16'h0000, 16'd2910);
    send_reading(16'h0000, 16'd20000);
    // right at the default limit and one step past it
    send_reading(16'h0000, 16'd23321);
    send_reading(16'h0000, 16'd23327);
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'hAAAA, 16'h5555);
    send_reading(16'h5555, 16'hAAAA);
    send_reading(16'hFFFF, 16'hFFFF);
    drain_readings();
  endtask

  task automatic test_register_extremes();
    write_reg(CfgMaxDist, 16'h0000);
    write_reg(CfgBacklight, 16'hFFFE);
    release_cfg();
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'h0100, 16'h0200);
    drain_readings();
    // limit above four digits clamps to the display cap
    write_reg(CfgMaxDist, 16'hFFFF);
    write_reg(CfgBacklight, 16'h0001);
    release_cfg();
    send_reading(16'h0000, 16'hFFFF);
    drain_readings();
    // unused index: must not touch either register
    write_reg(CfgUnused, 16'h0000);
    write_reg(4'((1 << CfgIdxW) - 1), 16'h0000);
    release_cfg();
    send_reading(16'h8000, 16'h7FFF);
    drain_readings();
    write_reg(CfgMaxDist, 16'd9999);
    release_cfg();
    send_reading(16'h0000, 16'hFFFF);
    drain_readings();
    write_reg(CfgMaxDist, 16'd10000);
    release_cfg();
    send_reading(16'h0000, 16'd58000);
    send_reading(16'h0000, 16'd1);
    drain_readings();
  endtask

  task automatic test_random_phases();
    logic [13:0] lim;
    logic [3:0]  idx;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 7))
        0:       lim = 14'd0;
        1:       lim = 14'($urandom_range(1, 99));
        2:       lim = 14'd4000;
        3:       lim = 14'd9999;
        4:       lim = 14'h3FFF;
        default: lim = 14'($urandom);
      endcase
      write_reg(CfgMaxDist, {2'($urandom), lim});
      write_reg(CfgBacklight, 16'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        idx = 4'($urandom_range(int'(CfgBacklight) + 1, (1 << CfgIdxW) - 1));
        write_reg(idx, 16'($urandom));
      end
      release_cfg();
      // hold one phase free of idling on both sides
      tx_calm = (phase == 3);
      rx_calm = (phase == 3);
      repeat (45) send_random_reading();
      drain_readings();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(CfgMaxDist, 16'h3FFF);
    release_cfg();
    rx_hold_cycles = 400;
    tx_calm = 1'b1;
    repeat (14) send_random_reading();
    tx_calm = 1'b0;
    // pause the sender until every pending byte has come out
    drain_readings();
  endtask

  task automatic test_no_idle();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (20) send_random_reading();
    drain_readings();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    meas.valid     = 1'b0;
    meas.rise_time = '0;
    meas.fall_time = '0;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.wdata      = '0;
    bytes.ready    = 1'b0;
    max_mm_q       = MaxDistReset;
    backlight_q    = BacklightReset;
    mismatches     = 0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    rx_hold_cycles = 0;
    rx_stall       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    test_no_idle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("TEST FAILED");
    $finish;
  end

endmodule
